### hdl/rpq_pkg.sv
// Shared types and constants for the record priority queue.
package rpq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [0:0] {
    MODE_INSERT = 1'b0,
    MODE_REMOVE = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } cell_op_t;

  typedef struct packed {
    logic [7:0]  priority_req;
    logic [30:0] account_id;
    logic [7:0]  holder_age;
    logic [30:0] phone_number;
  } record_t;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  priority_req;
    logic [30:0] account_id;
    logic [7:0]  holder_age;
    logic [30:0] phone_number;
  } in_t;

  typedef struct packed {
    status_t     status;
    logic [30:0] removed_account;
    logic [7:0]  removed_age;
    logic [30:0] removed_phone;
  } out_t;

  // Command broadcast to every cell in the chain.
  typedef struct packed {
    cell_op_t op;
    record_t  rec;
  } cell_cmd_t;

endpackage

### hdl/record_priority_queue.sv
// Top level of the record priority queue: cell chain, fill count and result register.
//
// Usage: each input beat on in_data is an insert (mode 0) or a remove of the
// head (mode 1). Every input beat yields exactly one result beat on out_data
// with a status: inserted, removed, queue empty or queue full. A remove
// returns the fields of the head record, which has the lowest priority value;
// equal priorities leave in arrival order. Other statuses carry zero fields.
// Records live in a chain of QUEUE_DEPTH cells; on each beat every cell
// compares against the broadcast record and shifts left, right or holds, so
// an insert or remove updates every cell at once, whatever the fill level.
// The result is registered and appears in the cycle after the input beat is accepted.
// Throughput: one beat per cycle while out_stall is low; the single result
// register sets this figure.
// When out_stall holds a waiting result, in_stall rises and the queue keeps
// its contents until the result is taken.
// Reset (rst, synchronous) empties the queue and drops any pending result.
module record_priority_queue import rpq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic [CNT_W-1:0]       fill;
  logic [CNT_W-1:0]       fill_next;
  logic                   accept;
  logic                   full;
  logic                   empty;
  logic [QUEUE_DEPTH-1:0] occupied;
  logic [QUEUE_DEPTH-1:0] cell_place;
  record_t                cell_rec [QUEUE_DEPTH];
  cell_cmd_t              cmd;
  out_t                   result;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (fill == CNT_W'(QUEUE_DEPTH));
  assign empty    = (fill == '0);

  always_comb begin
    cmd.op               = OP_HOLD;
    cmd.rec.priority_req = in_data.priority_req;
    cmd.rec.account_id   = in_data.account_id;
    cmd.rec.holder_age   = in_data.holder_age;
    cmd.rec.phone_number = in_data.phone_number;
    fill_next            = fill;
    result               = '0;
    if (in_data.mode == MODE_INSERT) begin
      if (full) begin
        result.status = ST_FULL;
      end else begin
        result.status = ST_INSERTED;
        if (accept) begin
          cmd.op    = OP_INSERT;
          fill_next = fill + CNT_W'(1);
        end
      end
    end else begin
      if (empty) begin
        result.status = ST_EMPTY;
      end else begin
        result.status          = ST_REMOVED;
        result.removed_account = cell_rec[0].account_id;
        result.removed_age     = cell_rec[0].holder_age;
        result.removed_phone   = cell_rec[0].phone_number;
        if (accept) begin
          cmd.op    = OP_REMOVE;
          fill_next = fill - CNT_W'(1);
        end
      end
    end
  end

  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic    left_place;
      record_t left_rec;
      record_t right_rec;

      assign occupied[i] = (CNT_W'(i) < fill);

      if (i == 0) begin : g_head
        assign left_place = 1'b0;
        assign left_rec   = cmd.rec;
      end else begin : g_body
        assign left_place = cell_place[i-1];
        assign left_rec   = cell_rec[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
        assign right_rec = cmd.rec;
      end else begin : g_mid
        assign right_rec = cell_rec[i+1];
      end

      rpq_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .occupied   (occupied[i]),
        .left_place (left_place),
        .left_rec   (left_rec),
        .right_rec  (right_rec),
        .place      (cell_place[i]),
        .rec        (cell_rec[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      fill <= fill_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound : assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(QUEUE_DEPTH))
    else $error("fill count exceeds queue depth");

  a_full_refused : assert property (@(posedge clk) disable iff (rst)
    accept && in_data.mode == MODE_INSERT && full |=> out_data.status == ST_FULL && $stable(fill))
    else $error("insert into full queue not refused");

  a_remove_count : assert property (@(posedge clk) disable iff (rst)
    accept && in_data.mode == MODE_REMOVE && !empty |=> $past(fill) == fill + CNT_W'(1))
    else $error("remove did not lower fill count");

  a_zero_fields : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_REMOVED |->
      out_data.removed_account == '0 && out_data.removed_age == '0 &&
      out_data.removed_phone == '0)
    else $error("non-remove result carries record fields");
`endif

endmodule

### hdl/rpq_cell.sv
// One slot of the sorted chain: holds a record and trades it with its neighbors.
module rpq_cell import rpq_pkg::*; (
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  logic      occupied,
  input  logic      left_place,
  input  record_t   left_rec,
  input  record_t   right_rec,
  output logic      place,
  output record_t   rec
);

  record_t rec_next;

  // The new record goes in front of the first held entry with a strictly
  // larger priority, or into the first empty slot.
  assign place = !occupied || (rec.priority_req > cmd.rec.priority_req);

  always_comb begin
    rec_next = rec;
    case (cmd.op)
      OP_INSERT: begin
        if (place) begin
          rec_next = left_place ? left_rec : cmd.rec;
        end
      end
      OP_REMOVE: begin
        rec_next = right_rec;
      end
      default: begin
        rec_next = rec;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rec <= rec_next;
  end

endmodule
